// File: rtl/core/fca_pkg.sv
// Shared types and constants for the flow cache with aging.
// No dependencies; used by the core and the testbench.
package fca_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam logic [15:0] TIMEOUT_RST = 16'd30;
  localparam logic [6:0] LIMIT_RST = 7'd64;
  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIND,
    ST_WRITE,
    ST_DONE
  } state_t;
endpackage

// File: rtl/core/flow_cache_with_aging_core.sv
// Flow cache with aging: exact-match five-tuple table with timeout sweep.
// Depends on fca_pkg. Slot contents live in one synchronous memory.
//
// One item is worked at a time. Lookup and sweep read every slot once before the
// result is shown; an insert into a table at its entry limit first runs an oldest-entry
// scan and then a key/free-slot scan, otherwise only the key/free-slot scan; clear reads
// no slot. The scan speed is set by the single read port of the slot memory, one slot
// per cycle. The result sits in an output register; a new item can be taken the cycle
// after it is delivered.
module flow_cache_with_aging_core #(
  parameter int CAPACITY = fca_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_protocol,
  input  logic [7:0]  in_app_type,
  input  logic        in_blocked,
  input  logic [15:0] in_confidence,
  input  logic [31:0] in_timestamp_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [7:0]  out_found_app_type,
  output logic        out_found_blocked,
  output logic [15:0] out_found_confidence,
  output logic [31:0] out_found_hit_count,
  output logic [31:0] out_found_created_ms,
  output logic [6:0]  out_removed_count,
  output logic [6:0]  out_entry_count,
  output logic [31:0] out_hit_total_out,
  output logic [31:0] out_miss_total_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);
  localparam int MW = 64 + 40 + 25 + 32 + 32;

  fca_pkg::state_t st_r, st_nxt;

  logic [MW-1:0] mem [CAPACITY];
  logic [MW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [MW-1:0] wr_data;
  logic wr_en;

  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0] tmo_r;
  logic [6:0] lim_r;
  logic [31:0] hit_tot_r, hit_tot_nxt, miss_tot_r, miss_tot_nxt;

  // captured item
  logic [1:0] op_r;
  logic [63:0] ka_r;
  logic [39:0] kp_r;
  logic [24:0] vd_r;
  logic [31:0] ts_r;
  logic [41:0] lim_ms_r;

  // scan state: issue index, returned-data index, pipe valid
  logic [AW-1:0] ia_r, ia_nxt, da_r, da_nxt;
  logic rv_r, rv_nxt, iss_done_r, iss_done_nxt;
  logic pick_v_r, pick_v_nxt;
  logic [AW-1:0] pick_r, pick_nxt;
  logic [31:0] pick_ts_r, pick_ts_nxt;
  logic hit_v_r, hit_v_nxt, free_v_r, free_v_nxt;
  logic [AW-1:0] hit_r, hit_nxt, free_r, free_nxt;
  logic [24:0] hvd_r, hvd_nxt;
  logic [31:0] hhits_r, hhits_nxt, hcr_r, hcr_nxt;
  logic [CW-1:0] rem_r, rem_nxt;

  logic ov_r, ov_nxt;
  logic [7:0] o_app_r, o_app_nxt;
  logic o_found_r, o_found_nxt, o_blk_r, o_blk_nxt;
  logic [15:0] o_conf_r, o_conf_nxt;
  logic [31:0] o_hits_r, o_hits_nxt, o_cr_r, o_cr_nxt;
  logic [6:0] o_rem_r, o_rem_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // fields of returned slot
  logic [63:0] q_ka;
  logic [39:0] q_kp;
  logic [24:0] q_vd;
  logic [31:0] q_hits, q_cr;
  assign {q_ka, q_kp, q_vd, q_hits, q_cr} = rd_data_r;
  logic q_valid;
  assign q_valid = valid_r[da_r];
  logic [CW-1:0] lim_eff;
  assign lim_eff = (32'(lim_r) > 32'(CAPACITY)) ? CW'(CAPACITY) : CW'(lim_r);
  logic signed [42:0] age;
  assign age = $signed({11'd0, ts_r}) - $signed({11'd0, q_cr});

  assign in_ready = (st_r == fca_pkg::ST_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    st_nxt = st_r;
    valid_nxt = valid_r; cnt_nxt = cnt_r;
    hit_tot_nxt = hit_tot_r; miss_tot_nxt = miss_tot_r;
    ia_nxt = ia_r; da_nxt = da_r; rv_nxt = 1'b0; iss_done_nxt = iss_done_r;
    pick_v_nxt = pick_v_r; pick_nxt = pick_r; pick_ts_nxt = pick_ts_r;
    hit_v_nxt = hit_v_r; hit_nxt = hit_r; free_v_nxt = free_v_r; free_nxt = free_r;
    hvd_nxt = hvd_r; hhits_nxt = hhits_r; hcr_nxt = hcr_r; rem_nxt = rem_r;
    ov_nxt = ov_r && !out_ready;
    o_found_nxt = o_found_r; o_app_nxt = o_app_r; o_blk_nxt = o_blk_r;
    o_conf_nxt = o_conf_r; o_hits_nxt = o_hits_r; o_cr_nxt = o_cr_r; o_rem_nxt = o_rem_r;
    rd_addr = ia_r; wr_en = 1'b0; wr_addr = hit_r; wr_data = rd_data_r;
    case (st_r)
      fca_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          ia_nxt = '0; iss_done_nxt = 1'b0;
          pick_v_nxt = 1'b0; hit_v_nxt = 1'b0; free_v_nxt = 1'b0; rem_nxt = '0;
          case (in_operation)
            fca_pkg::OP_CLEAR: st_nxt = fca_pkg::ST_DONE;
            fca_pkg::OP_INSERT:
              st_nxt = (cnt_r >= lim_eff && cnt_r != '0) ? fca_pkg::ST_SCAN
                                                         : fca_pkg::ST_FIND;
            default: st_nxt = fca_pkg::ST_FIND;
          endcase
        end
      end
      fca_pkg::ST_SCAN: begin
        // oldest-entry search for eviction
        if (!iss_done_r) begin
          rv_nxt = 1'b1; da_nxt = ia_r;
          if (ia_r == LAST) iss_done_nxt = 1'b1; else ia_nxt = ia_r + 1'b1;
        end
        if (rv_r && q_valid && (!pick_v_r || q_cr < pick_ts_r)) begin
          pick_v_nxt = 1'b1; pick_nxt = da_r; pick_ts_nxt = q_cr;
        end
        if (iss_done_r && !rv_r) begin
          valid_nxt[pick_r] = 1'b0; cnt_nxt = cnt_r - 1'b1;
          ia_nxt = '0; iss_done_nxt = 1'b0; st_nxt = fca_pkg::ST_FIND;
        end
      end
      fca_pkg::ST_FIND: begin
        if (!iss_done_r) begin
          rv_nxt = 1'b1; da_nxt = ia_r;
          if (ia_r == LAST) iss_done_nxt = 1'b1; else ia_nxt = ia_r + 1'b1;
        end
        if (rv_r) begin
          if (q_valid && !hit_v_r && q_ka == ka_r && q_kp == kp_r) begin
            hit_v_nxt = 1'b1; hit_nxt = da_r;
            hvd_nxt = q_vd; hhits_nxt = q_hits; hcr_nxt = q_cr;
          end
          if (!q_valid && !free_v_r) begin
            free_v_nxt = 1'b1; free_nxt = da_r;
          end
          if (op_r == fca_pkg::OP_SWEEP && q_valid && age > $signed({1'b0, lim_ms_r})) begin
            valid_nxt[da_r] = 1'b0; rem_nxt = rem_r + 1'b1;
          end
        end
        if (iss_done_r && !rv_r) st_nxt = fca_pkg::ST_WRITE;
      end
      fca_pkg::ST_WRITE: begin
        o_found_nxt = 1'b0; o_app_nxt = '0; o_blk_nxt = 1'b0; o_conf_nxt = '0;
        o_hits_nxt = '0; o_cr_nxt = '0; o_rem_nxt = '0;
        case (op_r)
          fca_pkg::OP_LOOKUP: begin
            if (hit_v_r) begin
              hhits_nxt = (hhits_r == '1) ? hhits_r : hhits_r + 1'b1;
              wr_en = 1'b1; wr_addr = hit_r;
              wr_data = {ka_r, kp_r, hvd_r, hhits_nxt, hcr_r};
              hit_tot_nxt = (hit_tot_r == '1) ? hit_tot_r : hit_tot_r + 1'b1;
              o_found_nxt = 1'b1; o_app_nxt = hvd_r[24:17]; o_blk_nxt = hvd_r[16];
              o_conf_nxt = hvd_r[15:0]; o_hits_nxt = hhits_nxt; o_cr_nxt = hcr_r;
            end else begin
              miss_tot_nxt = (miss_tot_r == '1) ? miss_tot_r : miss_tot_r + 1'b1;
            end
          end
          fca_pkg::OP_INSERT: begin
            wr_en = hit_v_r || free_v_r;
            wr_addr = hit_v_r ? hit_r : free_r;
            wr_data = {ka_r, kp_r, vd_r, 32'd0, ts_r};
            if (wr_en) begin
              valid_nxt[wr_addr] = 1'b1;
              if (!hit_v_r) cnt_nxt = cnt_r + 1'b1;
            end
          end
          fca_pkg::OP_SWEEP: begin
            cnt_nxt = cnt_r - rem_r; o_rem_nxt = 7'(rem_r);
          end
          default: ;
        endcase
        ov_nxt = 1'b1; st_nxt = fca_pkg::ST_IDLE;
      end
      fca_pkg::ST_DONE: begin
        valid_nxt = '0; cnt_nxt = '0; hit_tot_nxt = '0; miss_tot_nxt = '0;
        o_found_nxt = 1'b0; o_app_nxt = '0; o_blk_nxt = 1'b0; o_conf_nxt = '0;
        o_hits_nxt = '0; o_cr_nxt = '0; o_rem_nxt = '0;
        ov_nxt = 1'b1; st_nxt = fca_pkg::ST_IDLE;
      end
      default: st_nxt = fca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fca_pkg::ST_IDLE; valid_r <= '0; cnt_r <= '0;
      hit_tot_r <= '0; miss_tot_r <= '0; ov_r <= 1'b0; rv_r <= 1'b0;
      tmo_r <= fca_pkg::TIMEOUT_RST; lim_r <= fca_pkg::LIMIT_RST;
    end else begin
      st_r <= st_nxt; valid_r <= valid_nxt; cnt_r <= cnt_nxt;
      hit_tot_r <= hit_tot_nxt; miss_tot_r <= miss_tot_nxt;
      ov_r <= ov_nxt; rv_r <= rv_nxt;
      if (cfg_valid) begin
        if (cfg_index == fca_pkg::CFG_TIMEOUT) tmo_r <= cfg_data;
        else lim_r <= cfg_data[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_operation;
      ka_r <= {in_src_ip, in_dst_ip};
      kp_r <= {in_src_port, in_dst_port, in_protocol};
      vd_r <= {in_app_type, in_blocked, in_confidence};
      ts_r <= in_timestamp_ms;
      lim_ms_r <= 42'(tmo_r) * 42'(fca_pkg::MS_PER_S);
    end
    ia_r <= ia_nxt; da_r <= da_nxt; iss_done_r <= iss_done_nxt;
    pick_v_r <= pick_v_nxt; pick_r <= pick_nxt; pick_ts_r <= pick_ts_nxt;
    hit_v_r <= hit_v_nxt; hit_r <= hit_nxt; free_v_r <= free_v_nxt; free_r <= free_nxt;
    hvd_r <= hvd_nxt; hhits_r <= hhits_nxt; hcr_r <= hcr_nxt; rem_r <= rem_nxt;
    o_found_r <= o_found_nxt; o_app_r <= o_app_nxt; o_blk_r <= o_blk_nxt;
    o_conf_r <= o_conf_nxt; o_hits_r <= o_hits_nxt; o_cr_r <= o_cr_nxt;
    o_rem_r <= o_rem_nxt;
  end

  assign out_valid = ov_r;
  assign out_found = o_found_r;
  assign out_found_app_type = o_app_r;
  assign out_found_blocked = o_blk_r;
  assign out_found_confidence = o_conf_r;
  assign out_found_hit_count = o_hits_r;
  assign out_found_created_ms = o_cr_r;
  assign out_removed_count = o_rem_r;
  assign out_entry_count = 7'(cnt_r);
  assign out_hit_total_out = hit_tot_r;
  assign out_miss_total_out = miss_tot_r;
endmodule

// File: rtl/core/fca_checker.sv
// Port-level checks for the flow cache with aging, bound to the top level.
// Depends on fca_pkg only through the bound module.
module fca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [6:0]  out_removed_count,
  input logic [31:0] out_found_hit_count,
  input logic [31:0] out_hit_total_out
);
  // a beat in means no result sits waiting
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !out_valid) else $error("item taken with result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_found_hit_count == 32'd0) else $error("stale hit count");
  a_found_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_found_hit_count != 32'd0 && out_hit_total_out != 32'd0
                                  && out_removed_count == 7'd0))
    else $error("hit with zero count");
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready while busy");
endmodule

bind flow_cache_with_aging_core fca_checker u_fca_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_found(out_found), .out_removed_count(out_removed_count),
  .out_found_hit_count(out_found_hit_count), .out_hit_total_out(out_hit_total_out)
);

// File: tb/sv/flow_cache_with_aging_core_tb.sv
// Self-checking testbench for flow_cache_with_aging_core: directed and random
// flow operations over valid/ready channels, checked against a local table model.
// Depends on fca_pkg and the core RTL.
module flow_cache_with_aging_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } flow_key_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  app_cls;
    logic        blocked;
    logic [15:0] confidence;
    logic [31:0] hits;
    logic [31:0] created_at;
    logic [6:0]  removed;
    logic [6:0]  entries;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } flow_result_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_operation;
  logic [31:0] in_src_ip, in_dst_ip;
  logic [15:0] in_src_port, in_dst_port;
  logic [7:0]  in_protocol, in_app_type;
  logic        in_blocked;
  logic [15:0] in_confidence;
  logic [31:0] in_timestamp_ms;
  logic        out_valid, out_ready;
  logic        out_found;
  logic [7:0]  out_found_app_type;
  logic        out_found_blocked;
  logic [15:0] out_found_confidence;
  logic [31:0] out_found_hit_count, out_found_created_ms;
  logic [6:0]  out_removed_count, out_entry_count;
  logic [31:0] out_hit_total_out, out_miss_total_out;
  logic        cfg_valid, cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  flow_cache_with_aging_core dut (.*);

  // table model
  bit          tbl_valid [SLOTS];
  flow_key_t   tbl_key [SLOTS];
  logic [7:0]  tbl_app [SLOTS];
  logic        tbl_blocked [SLOTS];
  logic [15:0] tbl_conf [SLOTS];
  logic [31:0] tbl_hits [SLOTS];
  logic [31:0] tbl_created [SLOTS];
  logic [31:0] tot_hits, tot_misses;
  logic [15:0] timeout_s;
  logic [6:0]  entry_cap;

  flow_result_t pending_results[$];
  int          mismatches;
  bit          steady;
  flow_key_t   key_pool[32];
  logic [31:0] now_ms;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int key_slot(flow_key_t k);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic flow_result_t flow_predict(fca_pkg::op_t op, flow_key_t k,
                                                logic [7:0] app, logic blk,
                                                logic [15:0] conf, logic [31:0] ts);
    flow_result_t r;
    int s, pick, lim, n;
    longint limit_ms, age;
    r = '0;
    case (op)
      fca_pkg::OP_LOOKUP: begin
        s = key_slot(k);
        if (s >= 0) begin
          tbl_hits[s] = sat_inc(tbl_hits[s]);
          tot_hits = sat_inc(tot_hits);
          r.found = 1'b1;
          r.app_cls = tbl_app[s];
          r.blocked = tbl_blocked[s];
          r.confidence = tbl_conf[s];
          r.hits = tbl_hits[s];
          r.created_at = tbl_created[s];
        end else begin
          tot_misses = sat_inc(tot_misses);
        end
      end
      fca_pkg::OP_INSERT: begin
        lim = (entry_cap > SLOTS) ? SLOTS : entry_cap;
        n = 0;
        foreach (tbl_valid[i]) n += tbl_valid[i];
        if (n >= lim) begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && (pick < 0 || tbl_created[i] < tbl_created[pick])) pick = i;
          if (pick >= 0) tbl_valid[pick] = 0;
        end
        s = key_slot(k);
        if (s < 0)
          for (int i = 0; i < SLOTS; i++)
            if (!tbl_valid[i]) begin
              s = i;
              break;
            end
        if (s >= 0) begin
          tbl_valid[s] = 1;
          tbl_key[s] = k;
          tbl_app[s] = app;
          tbl_blocked[s] = blk;
          tbl_conf[s] = conf;
          tbl_hits[s] = '0;
          tbl_created[s] = ts;
        end
      end
      fca_pkg::OP_SWEEP: begin
        limit_ms = longint'(timeout_s) * 1000;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i]) begin
            age = longint'(ts) - longint'(tbl_created[i]);
            if (age > limit_ms) begin
              tbl_valid[i] = 0;
              r.removed++;
            end
          end
      end
      default: begin
        foreach (tbl_valid[i]) tbl_valid[i] = 0;
        tot_hits = '0;
        tot_misses = '0;
      end
    endcase
    n = 0;
    foreach (tbl_valid[i]) n += tbl_valid[i];
    r.entries = n[6:0];
    r.hit_total = tot_hits;
    r.miss_total = tot_misses;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("flow_cache_with_aging_core_tb NOT OK");
    $finish;
  end

  // result side: random backpressure, compare each accepted beat at the negedge before it
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 15)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                   : $urandom_range(1, 4);
    end
  end

  always @(negedge clk) begin
    flow_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_found, out_found_app_type, out_found_blocked, out_found_confidence,
              out_found_hit_count, out_found_created_ms, out_removed_count,
              out_entry_count, out_hit_total_out, out_miss_total_out};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  task automatic send_item(fca_pkg::op_t op, flow_key_t k, logic [7:0] app, logic blk,
                           logic [15:0] conf, logic [31:0] ts);
    in_valid <= 1'b1;
    in_operation <= op;
    {in_src_ip, in_dst_ip, in_src_port, in_dst_port, in_protocol} <= k;
    in_app_type <= app;
    in_blocked <= blk;
    in_confidence <= conf;
    in_timestamp_ms <= ts;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_results.insert(pending_results.size(), flow_predict(op, k, app, blk, conf, ts));
  endtask

  task automatic gap_in();
    int r, n;
    r = $urandom_range(0, 99);
    n = steady ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(20, 150);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == fca_pkg::CFG_TIMEOUT) timeout_s = value;
    else entry_cap = value[6:0];
  endtask

  function automatic flow_key_t rand_key();
    return {$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom)};
  endfunction

  task automatic test_directed();
    flow_key_t a, b, ones;
    ones = '1;
    a = key_pool[0];
    b = a;
    b.protocol = ~a.protocol;
    steady = 1;
    send_item(fca_pkg::OP_LOOKUP, ones, 8'hFF, 1'b1, 16'hFFFF, '1);
    send_item(fca_pkg::OP_INSERT, ones, 8'hFF, 1'b1, 16'hFFFF, 32'd1000);
    send_item(fca_pkg::OP_LOOKUP, ones, '0, '0, '0, '0);
    send_item(fca_pkg::OP_LOOKUP, ones, '0, '0, '0, '0);
    send_item(fca_pkg::OP_INSERT, '0, '0, '0, '0, '0);
    send_item(fca_pkg::OP_LOOKUP, '0, '0, '0, '0, '0);
    send_item(fca_pkg::OP_INSERT, a, 8'h5A, 1'b0, 16'h8000, 32'd500);
    send_item(fca_pkg::OP_LOOKUP, b, '0, '0, '0, '0);
    send_item(fca_pkg::OP_INSERT, a, 8'hA5, 1'b1, 16'h0001, 32'd700);
    send_item(fca_pkg::OP_LOOKUP, a, '0, '0, '0, '0);
    // age at the limit stays, one past it goes; earlier time never expires
    send_item(fca_pkg::OP_SWEEP, '0, '0, '0, '0, 32'd30_000);
    send_item(fca_pkg::OP_SWEEP, '0, '0, '0, '0, 32'd30_001);
    send_item(fca_pkg::OP_SWEEP, '0, '0, '0, '0, 32'd100);
    send_item(fca_pkg::OP_SWEEP, '0, '0, '0, '0, 32'd31_001);
    send_item(fca_pkg::OP_CLEAR, ones, '1, '1, '1, '1);
    send_item(fca_pkg::OP_LOOKUP, a, '0, '0, '0, '0);
    steady = 0;
    drain();
  endtask

  task automatic test_config_edges();
    // limit of two with a creation-time tie, then zero and above capacity
    write_reg(fca_pkg::CFG_LIMIT, 16'd2);
    send_item(fca_pkg::OP_INSERT, key_pool[1], 8'd1, 1'b0, 16'd1, 32'd50);
    send_item(fca_pkg::OP_INSERT, key_pool[2], 8'd2, 1'b1, 16'd2, 32'd50);
    send_item(fca_pkg::OP_INSERT, key_pool[2], 8'd3, 1'b0, 16'd3, 32'd60);
    send_item(fca_pkg::OP_LOOKUP, key_pool[1], '0, '0, '0, '0);
    send_item(fca_pkg::OP_LOOKUP, key_pool[2], '0, '0, '0, '0);
    write_reg(fca_pkg::CFG_LIMIT, 16'd0);
    send_item(fca_pkg::OP_INSERT, key_pool[3], 8'd4, 1'b0, 16'd4, 32'd10);
    send_item(fca_pkg::OP_INSERT, key_pool[3], 8'd5, 1'b1, 16'd5, 32'd10);
    write_reg(fca_pkg::CFG_LIMIT, 16'hFFFF);
    write_reg(fca_pkg::CFG_TIMEOUT, 16'd0);
    send_item(fca_pkg::OP_SWEEP, '0, '0, '0, '0, 32'd10);
    send_item(fca_pkg::OP_SWEEP, '0, '0, '0, '0, 32'd11);
    drain();
  endtask

  task automatic test_random(int items);
    int r;
    fca_pkg::op_t op;
    flow_key_t k;
    logic [31:0] ts;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      op = (r < 45) ? fca_pkg::OP_LOOKUP : (r < 85) ? fca_pkg::OP_INSERT :
           (r < 97) ? fca_pkg::OP_SWEEP : fca_pkg::OP_CLEAR;
      r = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, 31)];
      if (r < 8) k = rand_key();
      else if (r < 14) k.dst_port[$urandom_range(0, 15)] ^= 1'b1;
      now_ms += $urandom_range(0, 2500);
      r = $urandom_range(0, 99);
      ts = (r < 5) ? $urandom : (r < 12) ? now_ms - $urandom_range(0, 40_000) : now_ms;
      if (n == items / 2) drain();
      send_item(op, k, 8'($urandom), 1'($urandom), 16'($urandom), ts);
      gap_in();
    end
    drain();
  endtask

  initial begin
    mismatches = 0;
    steady = 0;
    stall_left = 0;
    now_ms = '0;
    timeout_s = fca_pkg::TIMEOUT_RST;
    entry_cap = fca_pkg::LIMIT_RST;
    tot_hits = '0;
    tot_misses = '0;
    foreach (tbl_valid[i]) tbl_valid[i] = 0;
    foreach (key_pool[i]) key_pool[i] = rand_key();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= fca_pkg::OP_LOOKUP;
    {in_src_ip, in_dst_ip, in_src_port, in_dst_port, in_protocol} <= '0;
    in_app_type <= '0;
    in_blocked <= 1'b0;
    in_confidence <= '0;
    in_timestamp_ms <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= fca_pkg::CFG_TIMEOUT;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed();
    test_config_edges();
    write_reg(fca_pkg::CFG_TIMEOUT, 16'd30);
    write_reg(fca_pkg::CFG_LIMIT, 16'd64);
    test_random(300);
    write_reg(fca_pkg::CFG_TIMEOUT, 16'd2);
    write_reg(fca_pkg::CFG_LIMIT, 16'd8);
    test_random(300);
    write_reg(fca_pkg::CFG_TIMEOUT, 16'hFFFF);
    write_reg(fca_pkg::CFG_LIMIT, 16'd1);
    test_random(250);
    write_reg(fca_pkg::CFG_TIMEOUT, 16'd0);
    write_reg(fca_pkg::CFG_LIMIT, 16'd127);
    test_random(250);
    write_reg(fca_pkg::CFG_TIMEOUT, 16'd5);
    write_reg(fca_pkg::CFG_LIMIT, 16'd33);
    test_random(300);
    write_reg(fca_pkg::CFG_TIMEOUT, 16'd12);
    write_reg(fca_pkg::CFG_LIMIT, 16'd0);
    test_random(200);
    write_reg(fca_pkg::CFG_TIMEOUT, 16'd1);
    write_reg(fca_pkg::CFG_LIMIT, 16'd16);
    test_random(300);

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("flow_cache_with_aging_core_tb OK");
    else
      $display("flow_cache_with_aging_core_tb NOT OK");
    $finish;
  end
endmodule
